// ----- src/fcsg_pkg.sv -----
`timescale 1ns / 1ps
package fcsg_pkg;

  localparam int COORD_BITS   = 12;
  localparam int POS_BITS     = COORD_BITS + 1;
  localparam int RADIUS_BITS  = 6;
  localparam int MAX_RADIUS   = 63;
  localparam int X_BITS       = RADIUS_BITS;
  localparam int Y_BITS       = RADIUS_BITS + 1;
  localparam int D_BITS       = RADIUS_BITS + 3;
  localparam int RESULT_LIMIT = 64;
  localparam int CNT_BITS     = $clog2(RESULT_LIMIT);

  typedef struct packed {
    logic load;  // take a new circle into the walk registers
    logic step;  // emit one span group and advance the walk
  } cmd_t;

  typedef struct packed {
    logic last;  // the group that step would emit now is the final one
  } sts_t;

endpackage

// ----- src/fcsg_if.sv -----
`timescale 1ns / 1ps
interface fcsg_in_if;
  import fcsg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius;

  modport source (output valid, center_x, center_y, radius, input ready);
  modport sink   (input valid, center_x, center_y, radius, output ready);
endinterface

interface fcsg_out_if;
  import fcsg_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] wide_left;
  logic signed [POS_BITS-1:0] wide_right;
  logic signed [POS_BITS-1:0] wide_row_low;
  logic signed [POS_BITS-1:0] wide_row_high;
  logic signed [POS_BITS-1:0] narrow_left;
  logic signed [POS_BITS-1:0] narrow_right;
  logic signed [POS_BITS-1:0] narrow_row_low;
  logic signed [POS_BITS-1:0] narrow_row_high;
  logic                       last;

  modport source (output valid, wide_left, wide_right, wide_row_low, wide_row_high,
                  narrow_left, narrow_right, narrow_row_low, narrow_row_high, last,
                  input ready);
  modport sink   (input valid, wide_left, wide_right, wide_row_low, wide_row_high,
                  narrow_left, narrow_right, narrow_row_low, narrow_row_high, last,
                  output ready);
endinterface

// ----- src/fcsg_datapath.sv -----
`timescale 1ns / 1ps
module fcsg_datapath
  import fcsg_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [RADIUS_BITS-1:0]       radius_i,
  output logic signed [POS_BITS-1:0]   wide_left_o,
  output logic signed [POS_BITS-1:0]   wide_right_o,
  output logic signed [POS_BITS-1:0]   wide_row_low_o,
  output logic signed [POS_BITS-1:0]   wide_row_high_o,
  output logic signed [POS_BITS-1:0]   narrow_left_o,
  output logic signed [POS_BITS-1:0]   narrow_right_o,
  output logic signed [POS_BITS-1:0]   narrow_row_low_o,
  output logic signed [POS_BITS-1:0]   narrow_row_high_o,
  output logic                         last_o
);

  localparam int DW = D_BITS + 1;  // headroom for the branch terms

  logic signed [COORD_BITS-1:0] cx_q, cy_q;
  logic [RADIUS_BITS-1:0]       r_q, r_sat;
  logic [X_BITS-1:0]            x_q, x_d;
  logic signed [Y_BITS-1:0]     y_q, y_d;
  logic signed [D_BITS-1:0]     d_q, d_d;
  logic [CNT_BITS-1:0]          cnt_q;

  logic signed [DW-1:0]         d_w, x2_w, y2_w, ry2_w, d_nx;
  logic signed [Y_BITS:0]       rm_y;
  logic                         last_w;

  logic signed [POS_BITS-1:0]   cx_w, cy_w, xo_w, yo_w;

  always_comb begin
    r_sat = radius_i;
    if (radius_i > RADIUS_BITS'(MAX_RADIUS)) begin
      r_sat = RADIUS_BITS'(MAX_RADIUS);
    end
  end

  always_comb begin
    d_w   = DW'(d_q);
    x2_w  = DW'(signed'({1'b0, x_q, 1'b0}));
    y2_w  = DW'(y_q) <<< 1;
    rm_y  = signed'({2'b00, r_q}) - (Y_BITS+1)'(y_q);
    ry2_w = DW'(rm_y) <<< 1;
    x_d   = x_q;
    y_d   = y_q;
    priority if (d_w >= x2_w) begin
      d_nx = d_w - x2_w - DW'(1);
      x_d  = x_q + X_BITS'(1);
    end else if (d_w < ry2_w) begin
      d_nx = d_w + y2_w - DW'(1);
      y_d  = y_q - Y_BITS'(1);
    end else begin
      d_nx = d_w + y2_w - x2_w - DW'(2);
      x_d  = x_q + X_BITS'(1);
      y_d  = y_q - Y_BITS'(1);
    end
    d_d = D_BITS'(d_nx);
    // stop once y drops below x, or at the result cap
    last_w = ((Y_BITS+1)'(y_d) < signed'({2'b00, x_d})) ||
             (cnt_q == CNT_BITS'(RESULT_LIMIT - 1));
  end

  assign sts_o.last = last_w;

  assign cx_w = POS_BITS'(cx_q);
  assign cy_w = POS_BITS'(cy_q);
  assign xo_w = POS_BITS'(signed'({1'b0, x_q}));
  assign yo_w = POS_BITS'(y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      r_q   <= '0;
      x_q   <= '0;
      y_q   <= '0;
      d_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cx_q  <= center_x_i;
      cy_q  <= center_y_i;
      r_q   <= r_sat;
      x_q   <= '0;
      y_q   <= Y_BITS'(signed'({1'b0, r_sat}));
      d_q   <= D_BITS'(signed'({1'b0, r_sat})) - D_BITS'(1);
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      x_q   <= x_d;
      y_q   <= y_d;
      d_q   <= d_d;
      cnt_q <= cnt_q + CNT_BITS'(1);
    end
  end

  // result register, loaded with the spans of the current walk point
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      wide_left_o       <= cx_w - yo_w;
      wide_right_o      <= cx_w + yo_w;
      wide_row_low_o    <= cy_w - xo_w;
      wide_row_high_o   <= cy_w + xo_w;
      narrow_left_o     <= cx_w - xo_w;
      narrow_right_o    <= cx_w + xo_w;
      narrow_row_low_o  <= cy_w - yo_w;
      narrow_row_high_o <= cy_w + yo_w;
      last_o            <= last_w;
    end
  end

endmodule

// ----- src/fcsg_ctrl.sv -----
`timescale 1ns / 1ps
module fcsg_ctrl
  import fcsg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_valid_i && in_ready_o;
  // advance only when the result register is free or being drained
  assign cmd_o.step  = (state_q == ST_WALK) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_o.load) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cmd_o.step && sts_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cmd_o.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_step_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> state_q == ST_WALK)
    else $error("step issued outside a walk");

  a_load_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_WALK && !cmd_o.load)
    else $error("load did not start a walk");

  a_last_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step && sts_i.last |=> state_q == ST_IDLE && out_valid_q)
    else $error("final beat did not end the walk");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !cmd_o.step)
    else $error("pending beat overwritten");

endmodule

// ----- src/filled_circle_span_generator.sv -----
`timescale 1ns / 1ps
// Output: after the circle is accepted, one beat per cycle while out_o.ready does not stall it.
// A circle of radius r yields about 0.71*r + 1 beats (one for radius zero, at most 64).
// Circles: the single walk unit advances one step a cycle while the output is not stalled,
// and a new circle is taken only once the previous walk has finished.
// Reset: rst_ni asynchronous, active low; clears the controller and walk registers.
module filled_circle_span_generator
  import fcsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fcsg_in_if.sink    in_i,
  fcsg_out_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  fcsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fcsg_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .center_x_i        (in_i.center_x),
    .center_y_i        (in_i.center_y),
    .radius_i          (in_i.radius),
    .wide_left_o       (out_o.wide_left),
    .wide_right_o      (out_o.wide_right),
    .wide_row_low_o    (out_o.wide_row_low),
    .wide_row_high_o   (out_o.wide_row_high),
    .narrow_left_o     (out_o.narrow_left),
    .narrow_right_o    (out_o.narrow_right),
    .narrow_row_low_o  (out_o.narrow_row_low),
    .narrow_row_high_o (out_o.narrow_row_high),
    .last_o            (out_o.last)
  );

endmodule

// ----- tb/sv/fcsg_span_checker.sv -----
`timescale 1ns / 1ps
module fcsg_span_checker
  import fcsg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fcsg_in_if   in_i,
  fcsg_out_if  out_i,
  output int   fail_cnt_o,
  output int   pending_o,
  output int   circles_o,
  output int   groups_o
);

  localparam int NUM_POS = 8;

  typedef struct packed {
    logic [NUM_POS-1:0][POS_BITS-1:0] pos;
    logic                             last;
  } span_group_t;

  span_group_t pending_spans[$];
  span_group_t want;
  span_group_t got;
  int          fail_cnt;
  int          circles;
  int          groups;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending_spans.size();
  assign circles_o  = circles;
  assign groups_o   = groups;

  function automatic string pos_name(int idx);
    case (idx)
      0:       return "wide_left";
      1:       return "wide_right";
      2:       return "wide_row_low";
      3:       return "wide_row_high";
      4:       return "narrow_left";
      5:       return "narrow_right";
      6:       return "narrow_row_low";
      default: return "narrow_row_high";
    endcase
  endfunction

  // Run the whole circle walk and queue one span group per iteration.
  task automatic walk_circle(input int cx, input int cy, input int radius);
    span_group_t grp;
    int          ox;
    int          oy;
    int          dec;
    int          r;
    int          n;
    bit          done;
    r    = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
    ox   = 0;
    oy   = r;
    dec  = r - 1;
    n    = 0;
    done = 1'b0;
    while (!done) begin
      grp.pos[0] = POS_BITS'(cx - oy);
      grp.pos[1] = POS_BITS'(cx + oy);
      grp.pos[2] = POS_BITS'(cy - ox);
      grp.pos[3] = POS_BITS'(cy + ox);
      grp.pos[4] = POS_BITS'(cx - ox);
      grp.pos[5] = POS_BITS'(cx + ox);
      grp.pos[6] = POS_BITS'(cy - oy);
      grp.pos[7] = POS_BITS'(cy + oy);
      grp.last   = 1'b0;
      n++;
      if (dec >= 2 * ox) begin
        dec -= 2 * ox + 1;
        ox  += 1;
      end else if (dec < 2 * (r - oy)) begin
        dec += 2 * oy - 1;
        oy  -= 1;
      end else begin
        dec += 2 * (oy - ox - 1);
        oy  -= 1;
        ox  += 1;
      end
      if (oy < ox || n >= RESULT_LIMIT) begin
        grp.last = 1'b1;
        done     = 1'b1;
      end
      pending_spans.insert(pending_spans.size(), grp);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_spans.delete();
      fail_cnt = 0;
      circles  = 0;
      groups   = 0;
    end else begin
      // Retire the output beat first: a beat in the same cycle as a new circle
      // cannot belong to that circle.
      if (out_i.valid && out_i.ready) begin
        groups++;
        got.pos[0] = out_i.wide_left;
        got.pos[1] = out_i.wide_right;
        got.pos[2] = out_i.wide_row_low;
        got.pos[3] = out_i.wide_row_high;
        got.pos[4] = out_i.narrow_left;
        got.pos[5] = out_i.narrow_right;
        got.pos[6] = out_i.narrow_row_low;
        got.pos[7] = out_i.narrow_row_high;
        got.last   = out_i.last;
        if (pending_spans.size() == 0) begin
          fail_cnt++;
          $display("%0t: span group beat with none expected (last %0b)", $time, got.last);
        end else begin
          want = pending_spans.pop_front();
          for (int i = 0; i < NUM_POS; i++) begin
            if (got.pos[i] !== want.pos[i]) begin
              fail_cnt++;
              $display("%0t: %s expected %0d actual %0d", $time, pos_name(i),
                       $signed(want.pos[i]), $signed(got.pos[i]));
            end
          end
          if (got.last !== want.last) begin
            fail_cnt++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        circles++;
        walk_circle(int'(in_i.center_x), int'(in_i.center_y), int'(in_i.radius));
      end
    end
  end

endmodule

// ----- tb/sv/filled_circle_span_generator_tb.sv -----
`timescale 1ns / 1ps
module filled_circle_span_generator_tb;
  import fcsg_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RAND_CIRCLES = 100;
  localparam int SEGMENT_LEN  = 20;

  logic clk;
  logic rst_n;
  bit   calm;
  int   cycle_cnt = 0;
  int   fail_cnt;
  int   pending;
  int   circles;
  int   groups;

  fcsg_in_if  in_bus ();
  fcsg_out_if out_bus ();

  filled_circle_span_generator i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  fcsg_span_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_bus),
    .out_i      (out_bus),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .circles_o  (circles),
    .groups_o   (groups)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_circle(input logic signed [COORD_BITS-1:0] cx,
                             input logic signed [COORD_BITS-1:0] cy,
                             input logic [RADIUS_BITS-1:0] r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_bus.valid    = 1'b0;
      in_bus.center_x = COORD_BITS'($urandom);
      in_bus.center_y = COORD_BITS'($urandom);
      in_bus.radius   = RADIUS_BITS'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_bus.valid    = 1'b1;
    in_bus.center_x = cx;
    in_bus.center_y = cy;
    in_bus.radius   = r;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic drain_spans();
    in_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  // Output side: stall a random number of cycles before each beat.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  initial begin
    logic [RADIUS_BITS-1:0] r;
    calm            = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.center_x = '0;
    in_bus.center_y = '0;
    in_bus.radius   = '0;
    rst_n           = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Zero radius collapses every span onto the centre.
    send_circle(12'sd0, 12'sd0, 6'd0);
    send_circle(-12'sd2048, -12'sd2048, 6'd0);
    send_circle(12'sd2047, 12'sd2047, 6'd0);
    // Largest radius at the coordinate corners drives the 13-bit positions past the 12-bit range.
    send_circle(-12'sd2048, -12'sd2048, 6'd63);
    send_circle(12'sd2047, 12'sd2047, 6'd63);
    send_circle(-12'sd2048, 12'sd2047, 6'd63);
    send_circle(12'sd2047, -12'sd2048, 6'd63);
    send_circle(-12'sd1, -12'sd1, 6'd63);
    send_circle(12'sd0, 12'sd0, 6'd1);
    send_circle(12'sd0, 12'sd0, 6'd2);
    send_circle(12'sd5, -12'sd5, 6'd3);
    send_circle(12'sd100, -12'sd100, 6'd10);
    send_circle(12'sh555, 12'shAAA, 6'b101010);
    send_circle(12'shAAA, 12'sh555, 6'b010101);
    calm = 1'b1;
    send_circle(12'sd7, 12'sd9, 6'd31);
    send_circle(-12'sd300, 12'sd42, 6'd32);
    calm = 1'b0;
    drain_spans();

    for (int seg = 0; seg < RAND_CIRCLES / SEGMENT_LEN; seg++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < SEGMENT_LEN; k++) begin
        // Mix many small circles with full-range ones.
        r = ($urandom_range(0, 3) == 0) ? RADIUS_BITS'($urandom_range(0, 7))
                                        : RADIUS_BITS'($urandom_range(0, MAX_RADIUS));
        send_circle(pick_coord(), pick_coord(), r);
      end
      if (seg == 0 || $urandom_range(0, 1) == 1) begin
        drain_spans();
      end
    end
    calm = 1'b0;

    drain_spans();
    repeat (8) @(posedge clk);

    $display("Covered %0d circles, radius 0 to %0d at corner and random centres,", circles,
             MAX_RADIUS);
    $display("with %0d span groups checked under random input and output stalls.", groups);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filled_circle_span_generator.f -----
src/fcsg_pkg.sv
src/fcsg_if.sv
src/fcsg_datapath.sv
src/fcsg_ctrl.sv
src/filled_circle_span_generator.sv
tb/sv/fcsg_span_checker.sv
tb/sv/filled_circle_span_generator_tb.sv
